### sv/sofr_pkg.sv
// ----------------------------------------------------------------------------
// sofr_pkg
// Shared types and constants for the start/end delimited frame receiver.
// ----------------------------------------------------------------------------
package sofr_pkg;

    // payload buffer geometry
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;

    // fixed field widths
    localparam int BYTE_W = 8;
    localparam int MAXP_W = 7;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 2;
    localparam int CMP_W  = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;

    // register reset values
    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd126;
    localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'd125;
    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 7'd62;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_START_BYTE  = 2'd0,
        REG_END_BYTE    = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } reg_index_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUFFER,
        ST_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic store;       // write received word into buffer, bump count
        logic clear_fill;  // empty the payload
        logic rd_start;    // point readout at first entry
        logic rd_advance;  // step readout to next entry
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic at_limit;
        logic fill_zero;
        logic rd_last;
    } dp_status_t;

endpackage

### sv/sofr_ctrl.sv
// ----------------------------------------------------------------------------
// sofr_ctrl
// Frame state machine: idle, buffering and readout of a completed frame.
// ----------------------------------------------------------------------------
module sofr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  sofr_pkg::dp_status_t status,
    output sofr_pkg::ctrl_cmd_t  cmd
);
    import sofr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    logic   out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && status.is_start) begin
                    state_next = ST_BUFFER;
                end
            end
            ST_BUFFER: begin
                if (in_fire && !status.is_start) begin
                    if (status.is_end) begin
                        state_next = status.fill_zero ? ST_IDLE : ST_EMIT;
                    end else if (status.at_limit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_fire && status.rd_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_fire && status.is_start) begin
                    cmd.clear_fill = 1'b1;
                end
            end
            ST_BUFFER: begin
                s_ready = 1'b1;
                if (in_fire) begin
                    if (status.is_start) begin
                        cmd.clear_fill = 1'b1;
                    end else if (status.is_end) begin
                        cmd.rd_start = 1'b1;
                    end else if (status.at_limit) begin
                        cmd.clear_fill = 1'b1;
                    end else begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (out_fire) begin
                    if (status.rd_last) begin
                        cmd.clear_fill = 1'b1;
                    end else begin
                        cmd.rd_advance = 1'b1;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/sofr_dp.sv
// ----------------------------------------------------------------------------
// sofr_dp
// Datapath: configuration registers, payload buffer, fill count and readout.
// ----------------------------------------------------------------------------
module sofr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sofr_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sofr_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic [sofr_pkg::BYTE_W-1:0]         s_rx_byte,
    input  sofr_pkg::ctrl_cmd_t                 cmd,
    output sofr_pkg::dp_status_t                status,
    output logic [sofr_pkg::BYTE_W-1:0]         m_payload_byte,
    output logic [sofr_pkg::POS_W-1:0]          m_byte_position,
    output logic [sofr_pkg::LEN_W-1:0]          m_payload_length,
    output logic                                m_last_byte
);
    import sofr_pkg::*;

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] end_byte_reg;
    logic [MAXP_W-1:0] max_payload_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] rd_addr_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] payload_mem [BUFFER_DEPTH];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg  <= START_BYTE_RST;
            end_byte_reg    <= END_BYTE_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_START_BYTE:  start_byte_reg  <= cfg_wdata;
                REG_END_BYTE:    end_byte_reg    <= cfg_wdata;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata[MAXP_W-1:0];
                default:         start_byte_reg  <= start_byte_reg;
            endcase
        end
    end

    // fill count
    always_comb begin
        fill_count_next = fill_count_reg;
        if (cmd.clear_fill) begin
            fill_count_next = '0;
        end else if (cmd.store) begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
        end else begin
            fill_count_reg <= fill_count_next;
        end
    end

    // readout address
    always_comb begin
        rd_addr_next = rd_addr_reg;
        if (cmd.rd_start) begin
            rd_addr_next = '0;
        end else if (cmd.rd_advance) begin
            rd_addr_next = rd_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg <= '0;
        end else begin
            rd_addr_reg <= rd_addr_next;
        end
    end

    // payload buffer, one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            payload_mem[fill_count_reg[ADDR_W-1:0]] <= s_rx_byte;
        end
        rd_data_reg <= payload_mem[rd_addr_next];
    end

    // status toward the controller
    always_comb begin
        status.is_start  = (s_rx_byte == start_byte_reg);
        status.is_end    = (s_rx_byte == end_byte_reg);
        status.at_limit  = (CMP_W'(fill_count_reg) >= CMP_W'(max_payload_reg))
                        || (fill_count_reg >= CNT_W'(BUFFER_DEPTH));
        status.fill_zero = (fill_count_reg == '0);
        status.rd_last   = ((CNT_W'(rd_addr_reg) + CNT_W'(1)) == fill_count_reg);
    end

    // result word
    assign m_payload_byte   = rd_data_reg;
    assign m_byte_position  = POS_W'(rd_addr_reg);
    assign m_payload_length = LEN_W'(fill_count_reg);
    assign m_last_byte      = status.rd_last;

endmodule

### sv/sof_eof_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// sof_eof_frame_receiver_top
// Receives a byte stream and delivers the payload of start/end framed frames.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_rx_byte) takes one received word per
// cycle while the block is idle or buffering a frame. Payload words go into
// a 64-entry buffer; an end word closes the frame and starts readout.
// Result channel (m_valid/m_ready) then delivers one word per payload byte
// with its position, the frame length and a last flag on the final word.
// During readout s_ready is low; result words come from the buffer's
// registered read port, a new one after each accepted word, and a stalled
// receiver holds the current result. The first result follows in the
// cycle after the end word, and input stays blocked until the frame's
// last word is accepted. Empty or overlength frames give no result and
// input continues. The cfg port writes start word, end word and payload
// limit by index (0, 1, 2); the user must write them only while the block
// is idle, which the block leaves unchecked. Synchronous active low reset
// restores idle, an empty payload and default registers, not buffer data.
// ----------------------------------------------------------------------------
module sof_eof_frame_receiver_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sofr_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sofr_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sofr_pkg::BYTE_W-1:0]         s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sofr_pkg::BYTE_W-1:0]         m_payload_byte,
    output logic [sofr_pkg::POS_W-1:0]          m_byte_position,
    output logic [sofr_pkg::LEN_W-1:0]          m_payload_length,
    output logic                                m_last_byte
);
    import sofr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // frame state machine
    sofr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // buffer and registers
    sofr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .status           (status),
        .m_payload_byte   (m_payload_byte),
        .m_byte_position  (m_byte_position),
        .m_payload_length (m_payload_length),
        .m_last_byte      (m_last_byte)
    );

endmodule

### tb/sof_eof_frame_receiver_checker.sv
// ----------------------------------------------------------------------------
// sof_eof_frame_receiver_checker
// Watches the configuration port and both word channels of the frame
// receiver, tracks the deframing state from the accepted input words and
// compares every delivered payload word against the oldest predicted one.
// ----------------------------------------------------------------------------
module sof_eof_frame_receiver_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sofr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [sofr_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [sofr_pkg::BYTE_W-1:0]   s_rx_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [sofr_pkg::BYTE_W-1:0]   m_payload_byte,
    input  logic [sofr_pkg::POS_W-1:0]    m_byte_position,
    input  logic [sofr_pkg::LEN_W-1:0]    m_payload_length,
    input  logic                          m_last_byte,
    output int                            mismatch_count,
    output int                            words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import sofr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [POS_W-1:0]  byte_position;
        logic [LEN_W-1:0]  payload_length;
        logic              last_byte;
    } payload_word_t;

    // register mirror
    logic [BYTE_W-1:0] cfg_sof;
    logic [BYTE_W-1:0] cfg_eof;
    logic [MAXP_W-1:0] cfg_max;

    // deframing state
    logic              buffering;
    int                fill_len;
    logic [BYTE_W-1:0] frame_buf [0:BUFFER_DEPTH-1];

    // payload words of closed frames not yet delivered
    payload_word_t     payload_due [$];

    // advance the deframer by one received word
    function automatic void deframe_word(input logic [BYTE_W-1:0] w);
        int            cap;
        payload_word_t nxt;
        cap = (int'(cfg_max) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(cfg_max);
        if (!buffering) begin
            if (w == cfg_sof) begin
                buffering = 1'b1;
                fill_len  = 0;
            end
        end else if (w == cfg_sof) begin
            // restart with an empty payload
            fill_len = 0;
        end else if (w != cfg_eof) begin
            // limit checked before the word is stored
            if (fill_len >= cap) begin
                buffering = 1'b0;
                fill_len  = 0;
            end else begin
                frame_buf[fill_len] = w;
                fill_len++;
            end
        end else begin
            // end word: emit the stored payload, nothing for an empty frame
            for (int k = 0; k < fill_len; k++) begin
                nxt.payload_byte   = frame_buf[k];
                nxt.byte_position  = POS_W'(k);
                nxt.payload_length = LEN_W'(fill_len);
                nxt.last_byte      = (k == fill_len - 1);
                payload_due.push_back(nxt);
            end
            buffering = 1'b0;
            fill_len  = 0;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [BYTE_W-1:0] want,
                                          input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // check one delivered payload word
    function automatic void check_payload_word();
        payload_word_t want;
        if (payload_due.size() == 0) begin
            $error("payload word with none expected: payload_byte %0d, byte_position %0d",
                   m_payload_byte, m_byte_position);
            mismatch_count++;
        end else begin
            want = payload_due.pop_front();
            compare_field("payload_byte", want.payload_byte, m_payload_byte);
            compare_field("byte_position", BYTE_W'(want.byte_position),
                          BYTE_W'(m_byte_position));
            compare_field("payload_length", BYTE_W'(want.payload_length),
                          BYTE_W'(m_payload_length));
            compare_field("last_byte", BYTE_W'(want.last_byte), BYTE_W'(m_last_byte));
        end
    endfunction

    // sample handshakes at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_sof   = START_BYTE_RST;
            cfg_eof   = END_BYTE_RST;
            cfg_max   = MAX_PAYLOAD_RST;
            buffering = 1'b0;
            fill_len  = 0;
            payload_due.delete();
        end else begin
            if (m_valid && m_ready)
                check_payload_word();
            if (s_valid && s_ready)
                deframe_word(s_rx_byte);
            if (cfg_we) begin
                case (cfg_index)
                    REG_START_BYTE:  cfg_sof = cfg_wdata;
                    REG_END_BYTE:    cfg_eof = cfg_wdata;
                    REG_MAX_PAYLOAD: cfg_max = cfg_wdata[MAXP_W-1:0];
                    default: ;
                endcase
            end
        end
        words_due = payload_due.size();
    end

endmodule

### tb/sof_eof_frame_receiver_top_tb.sv
// ----------------------------------------------------------------------------
// sof_eof_frame_receiver_top_tb
// Drives framed and broken byte streams into the frame receiver across
// several delimiter and payload limit settings and idling mixes; the checker
// beside the block predicts and compares every payload word.
// ----------------------------------------------------------------------------
module sof_eof_frame_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sofr_pkg::*;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [BYTE_W-1:0]  cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_rx_byte = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [BYTE_W-1:0]  m_payload_byte;
    logic [POS_W-1:0]   m_byte_position;
    logic [LEN_W-1:0]   m_payload_length;
    logic               m_last_byte;

    int                 mismatch_count;
    int                 words_due;

    // current register settings, kept for building streams
    logic [BYTE_W-1:0]  cur_sof = START_BYTE_RST;
    logic [BYTE_W-1:0]  cur_eof = END_BYTE_RST;
    logic [BYTE_W-1:0]  cur_max = BYTE_W'(MAX_PAYLOAD_RST);

    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 words_sent = 0;

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    sof_eof_frame_receiver_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_byte   (m_payload_byte),
        .m_byte_position  (m_byte_position),
        .m_payload_length (m_payload_length),
        .m_last_byte      (m_last_byte)
    );

    sof_eof_frame_receiver_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_byte   (m_payload_byte),
        .m_byte_position  (m_byte_position),
        .m_payload_length (m_payload_length),
        .m_last_byte      (m_last_byte),
        .mismatch_count   (mismatch_count),
        .words_due        (words_due)
    );

    // effective payload limit of the current setting
    function automatic int frame_cap();
        return (int'(cur_max[MAXP_W-1:0]) > BUFFER_DEPTH) ? BUFFER_DEPTH
                                                          : int'(cur_max[MAXP_W-1:0]);
    endfunction

    // random payload word that is neither delimiter
    function automatic logic [BYTE_W-1:0] pick_payload();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(255));
        while (b == cur_sof || b == cur_eof);
        return b;
    endfunction

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic [BYTE_W-1:0] w);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // start word, payload, optional restart in the middle, optional end word
    task automatic send_frame(input int len, input bit restart, input bit closed);
        send_word(cur_sof);
        for (int i = 0; i < len; i++) begin
            if (restart && i == len / 2)
                send_word(cur_sof);
            send_word(pick_payload());
        end
        if (closed)
            send_word(cur_eof);
    endtask

    // force the block back to idle and let every payload word drain
    task automatic settle();
        if (cur_sof != cur_eof)
            send_word(cur_eof);
        else
            repeat (frame_cap() + 1) send_word(pick_payload());
        s_valid <= 1'b0;
        do @(negedge aclk);
        while (words_due != 0);
        repeat (8) @(posedge aclk);
    endtask

    // write all three registers, block idle
    task automatic set_config(input logic [BYTE_W-1:0] sof, input logic [BYTE_W-1:0] eof,
                              input logic [BYTE_W-1:0] maxp);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_BYTE;
        cfg_wdata <= sof;
        @(posedge aclk);
        cfg_index <= REG_END_BYTE;
        cfg_wdata <= eof;
        @(posedge aclk);
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_wdata <= maxp;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_sof = sof;
        cur_eof = eof;
        cur_max = maxp;
    endtask

    // mostly well-formed frames with small payloads, plus broken ones and noise
    task automatic run_random(input int words);
        int stop_at;
        int pick;
        int len;
        int cap;
        stop_at = words_sent + words;
        cap     = frame_cap();
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 5)
                len = cap + 1;
            else if (pick < 15)
                len = $urandom_range(0, cap);
            else
                len = $urandom_range(0, (cap < 8) ? cap : 8);
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(len, 1'b0, 1'b1);
            else if (pick < 80)
                send_frame(len, 1'b1, 1'b1);
            else if (pick < 90)
                send_frame(len, 1'b0, 1'b0);
            else begin
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(2);
                    send_word((pick == 0) ? cur_sof :
                              (pick == 1) ? cur_eof : BYTE_W'($urandom_range(255)));
                end
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings
        send_word(8'd125);                                  // end word while idle
        send_word(8'd126);
        send_word(8'd125);                                  // empty frame
        send_word(8'd126);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h55);
        send_word(8'hAA);
        send_word(8'd125);                                  // extreme payload values
        send_word(8'd126);
        send_word(8'd1);
        send_word(8'd2);
        send_word(8'd126);                                  // restart mid-frame
        send_word(8'd3);
        send_word(8'd125);
        settle();

        // directed: limit of two, overlength drop then a frame at the limit
        set_config(8'd126, 8'd125, 8'd2);
        send_word(8'd126);
        send_word(8'd9);
        send_word(8'd8);
        send_word(8'd7);
        send_word(8'd7);
        send_word(8'd126);
        send_word(8'd4);
        send_word(8'd5);
        send_word(8'd125);
        settle();

        // directed: equal delimiters and a zero limit
        set_config(8'h42, 8'h42, 8'd0);
        send_word(8'h42);
        send_word(8'd1);
        send_word(8'h42);
        send_word(8'h42);
        send_word(8'd2);
        settle();

        // extreme delimiters, full buffer, no idling
        set_config(8'h00, 8'hFF, 8'd64);
        send_frame(BUFFER_DEPTH, 1'b0, 1'b1);
        run_random(45);
        settle();

        // swapped extremes, limit field at its top, sender idling
        idle_pct = 86;
        set_config(8'hFF, 8'h00, 8'd127);
        run_random(45);
        settle();

        // random delimiters, small limit, receiver stalling
        idle_pct  = 0;
        stall_pct = 86;
        a = BYTE_W'($urandom_range(255));
        do b = BYTE_W'($urandom_range(255));
        while (b == a);
        set_config(a, b, BYTE_W'($urandom_range(1, 16)));
        run_random(55);
        settle();

        // equal delimiters, both sides idling
        idle_pct  = 23;
        stall_pct = 23;
        a = BYTE_W'($urandom_range(255));
        set_config(a, a, 8'd20);
        run_random(20);
        settle();

        // zero limit drops every frame with payload
        set_config(8'd126, 8'd125, 8'd0);
        run_random(20);
        settle();

        // random setting across the full limit range
        a = BYTE_W'($urandom_range(255));
        do b = BYTE_W'($urandom_range(255));
        while (b == a);
        set_config(a, b, BYTE_W'($urandom_range(0, 64)));
        run_random(55);
        settle();

        if (mismatch_count == 0 && words_due == 0) begin
            $display("sof_eof_frame_receiver_top_tb OK");
        end else begin
            $display("sof_eof_frame_receiver_top_tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("sof_eof_frame_receiver_top_tb NOT OK");
        $finish;
    end

endmodule

### files.f
sv/sofr_pkg.sv
sv/sofr_ctrl.sv
sv/sofr_dp.sv
sv/sof_eof_frame_receiver_top.sv
tb/sof_eof_frame_receiver_checker.sv
tb/sof_eof_frame_receiver_top_tb.sv
